// ----- rtl/triangle_midpoint_subdivider_macros.svh -----
// Assertion helpers used by the subdivider RTL.
`ifndef TRIANGLE_MIDPOINT_SUBDIVIDER_MACROS_SVH
`define TRIANGLE_MIDPOINT_SUBDIVIDER_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define TMS_CHECK(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define TMS_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define TMS_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/tms_pkg.sv -----
package tms_pkg;

	localparam int VERTEX_DEPTH      = 4096;
	localparam int NORMAL_DEPTH      = 4096;
	localparam int EDGE_DEPTH        = 4096;
	localparam int NORMAL_PAIR_DEPTH = 4096;
	localparam int COORD_WIDTH       = 16;

	localparam int IDX_W = 12;
	localparam int VEC_W = 48;
	localparam int UV_W  = 32;
	localparam int ENT_W = 3 * IDX_W;

	localparam int MAX_VN    = (VERTEX_DEPTH > NORMAL_DEPTH) ? VERTEX_DEPTH : NORMAL_DEPTH;
	localparam int MAX_TB    = (EDGE_DEPTH > NORMAL_PAIR_DEPTH) ? EDGE_DEPTH : NORMAL_PAIR_DEPTH;
	localparam int MAX_DEPTH = (MAX_VN > MAX_TB) ? MAX_VN : MAX_TB;
	localparam int CNT_W     = $clog2(MAX_DEPTH + 1);

	localparam int VA_W = $clog2(VERTEX_DEPTH);
	localparam int NA_W = $clog2(NORMAL_DEPTH);
	localparam int EA_W = $clog2(EDGE_DEPTH);
	localparam int PA_W = $clog2(NORMAL_PAIR_DEPTH);

	localparam int LANES_W = 3 * COORD_WIDTH;
	localparam int VX_W    = (LANES_W > VEC_W) ? LANES_W : VEC_W;

	// stream payload widths, padded to whole bytes
	localparam int S_RAW_W  = VEC_W + 6 * IDX_W + 3 * UV_W;
	localparam int S_DATA_W = ((S_RAW_W + 7) / 8) * 8;
	localparam int M_RAW_W  = IDX_W + VEC_W + 6 * IDX_W + 2 * UV_W + UV_W;
	localparam int M_DATA_W = ((M_RAW_W + 7) / 8) * 8;

	localparam logic [1:0] OP_LOAD_VERTEX = 2'd0;
	localparam logic [1:0] OP_LOAD_NORMAL = 2'd1;
	localparam logic [1:0] OP_SUBDIVIDE   = 2'd2;
	localparam logic [1:0] OP_CLEAR       = 2'd3;

	localparam logic [1:0] KIND_VERTEX   = 2'd0;
	localparam logic [1:0] KIND_NORMAL   = 2'd1;
	localparam logic [1:0] KIND_TRIANGLE = 2'd2;
	localparam logic [1:0] KIND_OVERFLOW = 2'd3;

	typedef struct packed {
		logic       hit;
		logic [1:0] slot;
	} hit_t;

	typedef struct packed {
		logic init;
		logic hit_en;
		logic set_en;
	} match_ctl_t;

	// floor average of signed lanes, done with offset binary
	function automatic logic [VEC_W-1:0] avg_vec(input logic [VEC_W-1:0] a,
			input logic [VEC_W-1:0] b);
		logic [VX_W-1:0] ax;
		logic [VX_W-1:0] bx;
		logic [VX_W-1:0] r;
		logic [COORD_WIDTH:0] s;
		logic [COORD_WIDTH-1:0] sb;
		ax = VX_W'(a);
		bx = VX_W'(b);
		sb = {1'b1, {(COORD_WIDTH-1){1'b0}}};
		r = '0;
		for (int i = 0; i < 3; i++) begin
			s = {1'b0, ax[i*COORD_WIDTH +: COORD_WIDTH] ^ sb}
				+ {1'b0, bx[i*COORD_WIDTH +: COORD_WIDTH] ^ sb};
			r[i*COORD_WIDTH +: COORD_WIDTH] = s[COORD_WIDTH:1] ^ sb;
		end
		return r[VEC_W-1:0];
	endfunction

	function automatic logic [UV_W-1:0] avg_uv(input logic [UV_W-1:0] a,
			input logic [UV_W-1:0] b);
		logic [16:0] u;
		logic [16:0] v;
		u = {1'b0, a[31:16]} + {1'b0, b[31:16]};
		v = {1'b0, a[15:0]} + {1'b0, b[15:0]};
		return {u[16:1], v[16:1]};
	endfunction

	// which triangle edge a table entry names, either direction
	function automatic hit_t match_slot(input logic [IDX_W-1:0] e1, input logic [IDX_W-1:0] e2,
			input logic [IDX_W-1:0] c0, input logic [IDX_W-1:0] c1,
			input logic [IDX_W-1:0] c2);
		hit_t h;
		h = '0;
		if (c0 == e1) begin
			if (c1 == e2) h = '{hit: 1'b1, slot: 2'd0};
			else if (c2 == e2) h = '{hit: 1'b1, slot: 2'd2};
		end else if (c1 == e1) begin
			if (c0 == e2) h = '{hit: 1'b1, slot: 2'd0};
			else if (c2 == e2) h = '{hit: 1'b1, slot: 2'd1};
		end else if (c2 == e1) begin
			if (c0 == e2) h = '{hit: 1'b1, slot: 2'd2};
			else if (c1 == e2) h = '{hit: 1'b1, slot: 2'd1};
		end
		return h;
	endfunction

endpackage

// ----- rtl/tms_ram.sv -----
module tms_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/tms_match.sv -----
module tms_match (
	input  logic                                clk,
	input  logic                                arst_n,
	input  tms_pkg::match_ctl_t                 ctl,
	input  logic [2:0]                          init_found,
	input  logic [2:0][tms_pkg::IDX_W-1:0]      init_mid,
	input  logic [2:0][tms_pkg::IDX_W-1:0]      corners,
	input  logic [tms_pkg::ENT_W-1:0]           entry,
	input  logic [1:0]                          set_slot,
	input  logic [tms_pkg::IDX_W-1:0]           set_mid,
	output logic [2:0]                          found,
	output logic [2:0][tms_pkg::IDX_W-1:0]      mids
);
	import tms_pkg::*;

	logic [2:0]            found_q;
	logic [2:0][IDX_W-1:0] mids_q;
	hit_t                  h;

	// entry layout: end 1, end 2, midpoint index
	assign h = match_slot(entry[ENT_W-1 -: IDX_W], entry[2*IDX_W-1 -: IDX_W],
		corners[0], corners[1], corners[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= '0;
		end else if (ctl.init) begin
			found_q <= init_found;
		end else if (ctl.hit_en && h.hit) begin
			found_q[h.slot] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.init) begin
			mids_q <= init_mid;
		end else if (ctl.set_en) begin
			mids_q[set_slot] <= set_mid;
		end else if (ctl.hit_en && h.hit) begin
			mids_q[h.slot] <= entry[IDX_W-1:0];
		end
	end

	assign found = found_q;
	assign mids  = mids_q;

endmodule

// ----- rtl/triangle_midpoint_subdivider.sv -----
// Midpoint subdivider, one pass of 1-to-4 splitting.
// Input stream s_*: tuser is the operation, tdata the vector, corner indices and uvs.
// A load answers one result from the load state once the output is free; the next
// input is taken when the sequencer is back in idle.
// A clear answers nothing.
// A triangle scans the edge and normal pair tables together, one entry a cycle through
// the table read ports, then checks capacity. Each new vertex or normal then takes a
// slot pick, two store reads through the single read port, an average and a write
// back; a slot already found takes only its pick. Last come the four triangles.
// Output stream m_*: tuser is the result kind, tlast marks the last result of an input.
// One input is in work at a time; s_tready is high only between items. A result waits
// in the output register while m_tready is low and the sequencer holds there.
// Reset clears all counts, so stores and tables start empty; store contents are not
// cleared, and entries never loaded are not to be read.
module triangle_midpoint_subdivider (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// packed_vector, corner_vertex_a/b/c, corner_normal_a/b/c, corner_uv_a/b/c
	input  logic [tms_pkg::S_DATA_W-1:0]   s_tdata,
	// operation
	input  logic [1:0]                     s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// new_index, new_vector, out_vertex_a/b/c, out_normal_a/b/c, out_uv_pair_ab,
	// out_uv_c, zero pad
	output logic [tms_pkg::M_DATA_W-1:0]   m_tdata,
	// result_kind
	output logic [1:0]                     m_tuser,
	output logic                           m_tlast
);
	import tms_pkg::*;

`include "triangle_midpoint_subdivider_macros.svh"

	localparam int ST_W = 4;
	localparam logic [ST_W-1:0] ST_IDLE  = 4'd0;
	localparam logic [ST_W-1:0] ST_LOAD  = 4'd1;
	localparam logic [ST_W-1:0] ST_SCAN  = 4'd2;
	localparam logic [ST_W-1:0] ST_CHECK = 4'd3;
	localparam logic [ST_W-1:0] ST_OVF   = 4'd4;
	localparam logic [ST_W-1:0] ST_PICK  = 4'd5;
	localparam logic [ST_W-1:0] ST_RDA   = 4'd6;
	localparam logic [ST_W-1:0] ST_RDB   = 4'd7;
	localparam logic [ST_W-1:0] ST_CAP   = 4'd8;
	localparam logic [ST_W-1:0] ST_WR    = 4'd9;
	localparam logic [ST_W-1:0] ST_TRI   = 4'd10;

	logic [ST_W-1:0] state_q, state_d;

	// input fields
	logic [1:0]            s_op;
	logic [2:0][IDX_W-1:0] s_cv, s_cn;
	logic                  s_acc;

	assign s_op  = s_tuser;
	assign s_acc = s_tvalid && s_tready;
	assign s_cv  = s_tdata[VEC_W +: 3*IDX_W];
	assign s_cn  = s_tdata[VEC_W + 3*IDX_W +: 3*IDX_W];

	logic [1:0]            op_q;
	logic [VEC_W-1:0]      vec_q;
	logic [2:0][IDX_W-1:0] cv_q, cn_q;
	logic [2:0][UV_W-1:0]  uv_q;

	logic [CNT_W-1:0] vcnt_q, ncnt_q, ecnt_q, pcnt_q, j_q;
	logic             rd_e_s1, rd_n_s1;
	logic [1:0]       slot_q;
	logic             norm_q;
	logic [1:0]       tri_q;
	logic [VEC_W-1:0] va_q, vb_q;

	// output register
	logic                m_tvalid_q;
	logic [M_DATA_W-1:0] m_tdata_q;
	logic [1:0]          m_tuser_q;
	logic                m_tlast_q;
	logic                out_free, out_load;
	logic [1:0]          o_kind;
	logic [IDX_W-1:0]    o_idx;
	logic [VEC_W-1:0]    o_vec;
	logic [2:0][IDX_W-1:0] o_v, o_n;
	logic [2:0][UV_W-1:0]  o_uv;
	logic                o_last;

	assign out_free = !m_tvalid_q || m_tready;

	// memories
	logic [VEC_W-1:0] vs_rdata, ns_rdata, vs_wdata, ns_wdata;
	logic [ENT_W-1:0] et_rdata, pt_rdata, tb_wdata;
	logic             vs_we, ns_we, et_we, pt_we;
	logic [IDX_W-1:0] idx_a, idx_b;

	// match units
	match_ctl_t            e_ctl, n_ctl;
	logic [2:0]            fv, fn, n_init_found;
	logic [2:0][IDX_W-1:0] mv, mn;
	logic [IDX_W-1:0]      new_idx;

	// scan control
	logic issue_e, issue_n;
	assign issue_e = (state_q == ST_SCAN) && (j_q < ecnt_q);
	assign issue_n = (state_q == ST_SCAN) && (j_q < pcnt_q);

	// capacity check
	logic [1:0]       needv, needn;
	logic             cap_ovf;
	assign needv = 2'(3 - $countones(fv));
	assign needn = 2'(3 - $countones(fn));
	assign cap_ovf = ({1'b0, vcnt_q} + (CNT_W+1)'(needv) > (CNT_W+1)'(VERTEX_DEPTH))
		|| ({1'b0, ecnt_q} + (CNT_W+1)'(needv) > (CNT_W+1)'(EDGE_DEPTH))
		|| ({1'b0, ncnt_q} + (CNT_W+1)'(needn) > (CNT_W+1)'(NORMAL_DEPTH))
		|| ({1'b0, pcnt_q} + (CNT_W+1)'(needn) > (CNT_W+1)'(NORMAL_PAIR_DEPTH));

	// slot walk over vertex edges then normal pairs
	logic [1:0]      slot_b, adv_slot;
	logic            adv_norm, cur_found;
	logic [ST_W-1:0] adv_state;
	assign slot_b    = (slot_q == 2'd2) ? 2'd0 : slot_q + 2'd1;
	assign cur_found = norm_q ? fn[slot_q] : fv[slot_q];
	always_comb begin
		adv_slot  = slot_b;
		adv_norm  = norm_q;
		adv_state = ST_PICK;
		if (slot_q == 2'd2) begin
			if (norm_q) begin
				adv_state = ST_TRI;
			end else begin
				adv_norm = 1'b1;
			end
		end
	end

	assign idx_a = norm_q ? cn_q[slot_q] : cv_q[slot_q];
	assign idx_b = norm_q ? cn_q[slot_b] : cv_q[slot_b];

	// out-of-range indices read as zero
	logic oob_a, oob_b;
	assign oob_a = norm_q ? (32'(idx_a) >= NORMAL_DEPTH) : (32'(idx_a) >= VERTEX_DEPTH);
	assign oob_b = norm_q ? (32'(idx_b) >= NORMAL_DEPTH) : (32'(idx_b) >= VERTEX_DEPTH);

	logic [VEC_W-1:0] avg_q_in, st_rdata;
	assign st_rdata = norm_q ? ns_rdata : vs_rdata;
	assign avg_q_in = avg_vec(va_q, vb_q);
	assign new_idx  = norm_q ? IDX_W'(ncnt_q) : IDX_W'(vcnt_q);

	logic load_ok;
	assign load_ok = (op_q == OP_LOAD_VERTEX) ? (32'(vcnt_q) < VERTEX_DEPTH)
		: (32'(ncnt_q) < NORMAL_DEPTH);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_acc) begin
					unique case (s_op)
						OP_LOAD_VERTEX, OP_LOAD_NORMAL: state_d = ST_LOAD;
						OP_SUBDIVIDE: state_d = ST_SCAN;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_LOAD: if (out_free) state_d = ST_IDLE;
			ST_SCAN: begin
				if (!issue_e && !issue_n && !rd_e_s1 && !rd_n_s1) state_d = ST_CHECK;
			end
			ST_CHECK: state_d = cap_ovf ? ST_OVF : ST_PICK;
			ST_OVF: if (out_free) state_d = ST_IDLE;
			ST_PICK: state_d = cur_found ? adv_state : ST_RDA;
			ST_RDA: state_d = ST_RDB;
			ST_RDB: state_d = ST_CAP;
			ST_CAP: state_d = ST_WR;
			ST_WR: if (out_free) state_d = adv_state;
			ST_TRI: if (out_free && tri_q == 2'd3) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			vcnt_q  <= '0;
			ncnt_q  <= '0;
			ecnt_q  <= '0;
			pcnt_q  <= '0;
			j_q     <= '0;
			rd_e_s1 <= 1'b0;
			rd_n_s1 <= 1'b0;
			slot_q  <= '0;
			norm_q  <= 1'b0;
			tri_q   <= '0;
		end else begin
			state_q <= state_d;
			rd_e_s1 <= issue_e;
			rd_n_s1 <= issue_n;
			if (issue_e || issue_n) j_q <= j_q + 1'b1;
			if (s_acc && s_op == OP_CLEAR) begin
				ecnt_q <= '0;
				pcnt_q <= '0;
			end
			if (s_acc) begin
				j_q    <= '0;
				slot_q <= '0;
				norm_q <= 1'b0;
				tri_q  <= '0;
			end
			if (state_q == ST_LOAD && out_free && load_ok) begin
				if (op_q == OP_LOAD_VERTEX) vcnt_q <= vcnt_q + 1'b1;
				else ncnt_q <= ncnt_q + 1'b1;
			end
			if ((state_q == ST_PICK && cur_found) || (state_q == ST_WR && out_free)) begin
				slot_q <= adv_slot;
				norm_q <= adv_norm;
			end
			if (state_q == ST_WR && out_free) begin
				if (norm_q) begin
					ncnt_q <= ncnt_q + 1'b1;
					pcnt_q <= pcnt_q + 1'b1;
				end else begin
					vcnt_q <= vcnt_q + 1'b1;
					ecnt_q <= ecnt_q + 1'b1;
				end
			end
			if (state_q == ST_TRI && out_free) tri_q <= tri_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			op_q  <= s_op;
			vec_q <= s_tdata[VEC_W-1:0];
			cv_q  <= s_cv;
			cn_q  <= s_cn;
			uv_q  <= s_tdata[VEC_W + 6*IDX_W +: 3*UV_W];
		end
		if (state_q == ST_RDB) va_q <= oob_a ? '0 : st_rdata;
		if (state_q == ST_CAP) vb_q <= oob_b ? '0 : st_rdata;
	end

	// stores and tables
	assign vs_we    = (state_q == ST_LOAD && out_free && load_ok && op_q == OP_LOAD_VERTEX)
		|| (state_q == ST_WR && out_free && !norm_q);
	assign ns_we    = (state_q == ST_LOAD && out_free && load_ok && op_q == OP_LOAD_NORMAL)
		|| (state_q == ST_WR && out_free && norm_q);
	assign et_we    = state_q == ST_WR && out_free && !norm_q;
	assign pt_we    = state_q == ST_WR && out_free && norm_q;
	assign vs_wdata = (state_q == ST_LOAD) ? vec_q : avg_q_in;
	assign ns_wdata = vs_wdata;
	assign tb_wdata = {idx_a, idx_b, new_idx};

	logic [IDX_W-1:0] rd_idx;
	assign rd_idx = (state_q == ST_RDA) ? idx_a : idx_b;

	tms_ram #(.WIDTH(VEC_W), .DEPTH(VERTEX_DEPTH)) u_vertex_store (
		.clk(clk), .we(vs_we), .waddr(VA_W'(vcnt_q)), .wdata(vs_wdata),
		.raddr(VA_W'(rd_idx)), .rdata(vs_rdata)
	);

	tms_ram #(.WIDTH(VEC_W), .DEPTH(NORMAL_DEPTH)) u_normal_store (
		.clk(clk), .we(ns_we), .waddr(NA_W'(ncnt_q)), .wdata(ns_wdata),
		.raddr(NA_W'(rd_idx)), .rdata(ns_rdata)
	);

	tms_ram #(.WIDTH(ENT_W), .DEPTH(EDGE_DEPTH)) u_edge_table (
		.clk(clk), .we(et_we), .waddr(EA_W'(ecnt_q)), .wdata(tb_wdata),
		.raddr(EA_W'(j_q)), .rdata(et_rdata)
	);

	tms_ram #(.WIDTH(ENT_W), .DEPTH(NORMAL_PAIR_DEPTH)) u_pair_table (
		.clk(clk), .we(pt_we), .waddr(PA_W'(pcnt_q)), .wdata(tb_wdata),
		.raddr(PA_W'(j_q)), .rdata(pt_rdata)
	);

	// equal normal indices reuse that normal
	always_comb begin
		for (int i = 0; i < 3; i++) n_init_found[i] = s_cn[i] == s_cn[(i + 1) % 3];
	end

	assign e_ctl = '{init: s_acc && s_op == OP_SUBDIVIDE, hit_en: rd_e_s1,
		set_en: et_we};
	assign n_ctl = '{init: s_acc && s_op == OP_SUBDIVIDE, hit_en: rd_n_s1,
		set_en: pt_we};

	tms_match u_edge_match (
		.clk(clk), .arst_n(arst_n), .ctl(e_ctl), .init_found(3'b000), .init_mid('0),
		.corners(cv_q), .entry(et_rdata), .set_slot(slot_q), .set_mid(new_idx),
		.found(fv), .mids(mv)
	);

	tms_match u_pair_match (
		.clk(clk), .arst_n(arst_n), .ctl(n_ctl), .init_found(n_init_found), .init_mid(s_cn),
		.corners(cn_q), .entry(pt_rdata), .set_slot(slot_q), .set_mid(new_idx),
		.found(fn), .mids(mn)
	);

	// result selection
	logic [2:0][UV_W-1:0] muv;
	always_comb begin
		for (int i = 0; i < 3; i++) muv[i] = avg_uv(uv_q[i], uv_q[(i + 1) % 3]);
	end

	always_comb begin
		out_load = 1'b0;
		o_kind   = KIND_OVERFLOW;
		o_idx    = '0;
		o_vec    = '0;
		o_v      = '0;
		o_n      = '0;
		o_uv     = '0;
		o_last   = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				out_load = out_free;
				o_last   = 1'b1;
				if (load_ok) begin
					o_kind = op_q;
					o_idx  = (op_q == OP_LOAD_VERTEX) ? IDX_W'(vcnt_q) : IDX_W'(ncnt_q);
					o_vec  = vec_q;
				end
			end
			ST_OVF: begin
				out_load = out_free;
				o_last   = 1'b1;
			end
			ST_WR: begin
				out_load = out_free;
				o_kind   = norm_q ? KIND_NORMAL : KIND_VERTEX;
				o_idx    = new_idx;
				o_vec    = avg_q_in;
			end
			ST_TRI: begin
				out_load = out_free;
				o_kind   = KIND_TRIANGLE;
				o_last   = tri_q == 2'd3;
				case (tri_q)
					2'd0: begin
						o_v  = {mv[2], mv[0], cv_q[0]};
						o_n  = {mn[2], mn[0], cn_q[0]};
						o_uv = {muv[2], muv[0], uv_q[0]};
					end
					2'd1: begin
						o_v  = {mv[2], mv[1], mv[0]};
						o_n  = {mn[2], mn[1], mn[0]};
						o_uv = {muv[2], muv[1], muv[0]};
					end
					2'd2: begin
						o_v  = {mv[1], cv_q[1], mv[0]};
						o_n  = {mn[1], cn_q[1], mn[0]};
						o_uv = {muv[1], uv_q[1], muv[0]};
					end
					default: begin
						o_v  = {cv_q[2], mv[1], mv[2]};
						o_n  = {cn_q[2], mn[1], mn[2]};
						o_uv = {uv_q[2], muv[1], muv[2]};
					end
				endcase
			end
			default: out_load = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tuser_q <= o_kind;
			m_tlast_q <= o_last;
			m_tdata_q <= M_DATA_W'({o_uv[2], o_uv[0], o_uv[1], o_n, o_v, o_vec, o_idx});
		end
	end

	assign s_tready = state_q == ST_IDLE;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

	`TMS_IMPLY(a_out_no_clobber, out_load, !m_tvalid_q || m_tready, "pending result overwritten")
	`TMS_CHECK(a_vcnt_range, 32'(vcnt_q) <= VERTEX_DEPTH, "vertex count past depth")
	`TMS_NEXT(a_sub_scan, s_acc && s_op == OP_SUBDIVIDE, state_q == ST_SCAN, "no scan after triangle")
	`TMS_IMPLY(a_scan_ptr, state_q == ST_SCAN, (j_q <= ecnt_q) || (j_q <= pcnt_q), "scan ran past tables")

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
	import tms_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int STORE_N     = 4096;

	typedef struct {
		logic [1:0]  op;
		logic [47:0] vec;
		logic [11:0] cv[3];
		logic [11:0] cn[3];
		logic [31:0] uv[3];
	} req_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [11:0] idx;
		logic [47:0] vec;
		logic [11:0] va, vb, vc;
		logic [11:0] na, nb, nc;
		logic [63:0] uvab;
		logic [31:0] uvc;
		logic        last;
	} res_t;

	class subdiv_scoreboard;
		logic [47:0] vstore[STORE_N];
		logic [47:0] nstore[STORE_N];
		logic [11:0] edge_lo[STORE_N], edge_hi[STORE_N], edge_mid[STORE_N];
		logic [11:0] pair_lo[STORE_N], pair_hi[STORE_N], pair_mid[STORE_N];
		int vcount, ncount, ecount, pcount;
		res_t pending[$];
		int mismatches;

		function void add_exp(res_t r);
			pending.insert(pending.size(), r);
		endfunction

		function logic [47:0] lane_avg(logic [47:0] a, logic [47:0] b);
			logic [16:0] s;
			logic [47:0] r;
			for (int i = 0; i < 3; i++) begin
				s = {1'b0, a[i*16 +: 16] ^ 16'h8000} + {1'b0, b[i*16 +: 16] ^ 16'h8000};
				r[i*16 +: 16] = s[16:1] ^ 16'h8000;
			end
			return r;
		endfunction

		function logic [31:0] uv_avg(logic [31:0] a, logic [31:0] b);
			logic [16:0] u, v;
			u = {1'b0, a[31:16]} + {1'b0, b[31:16]};
			v = {1'b0, a[15:0]} + {1'b0, b[15:0]};
			return {u[16:1], v[16:1]};
		endfunction

		// creation-order scan, later hits overwrite earlier ones
		function void lookup(bit normals, logic [11:0] c[3], inout logic [11:0] mid[3],
				inout bit hit[3]);
			int n;
			int s;
			logic [11:0] e1, e2, m;
			n = normals ? pcount : ecount;
			for (int j = 0; j < n; j++) begin
				e1 = normals ? pair_lo[j] : edge_lo[j];
				e2 = normals ? pair_hi[j] : edge_hi[j];
				m = normals ? pair_mid[j] : edge_mid[j];
				s = -1;
				if (c[0] == e1) begin
					if (c[1] == e2) s = 0;
					else if (c[2] == e2) s = 2;
				end else if (c[1] == e1) begin
					if (c[0] == e2) s = 0;
					else if (c[2] == e2) s = 1;
				end else if (c[2] == e1) begin
					if (c[0] == e2) s = 2;
					else if (c[1] == e2) s = 1;
				end
				if (s >= 0) begin
					mid[s] = m;
					hit[s] = 1;
				end
			end
		endfunction

		function res_t tri_res(logic [11:0] v[3], logic [11:0] n[3], logic [31:0] u[3]);
			res_t r;
			r = '0;
			r.kind = KIND_TRIANGLE;
			{r.va, r.vb, r.vc} = {v[0], v[1], v[2]};
			{r.na, r.nb, r.nc} = {n[0], n[1], n[2]};
			r.uvab = {u[0], u[1]};
			r.uvc = u[2];
			return r;
		endfunction

		function void note_transfer(req_t it);
			res_t r;
			logic [11:0] mv[3], mn[3], a3[3], b3[3];
			logic [31:0] mu[3], u3[3];
			bit fv[3], fn[3];
			int needv, needn;
			r = '0;
			if (it.op == OP_CLEAR) begin
				ecount = 0;
				pcount = 0;
				return;
			end
			if (it.op == OP_LOAD_VERTEX || it.op == OP_LOAD_NORMAL) begin
				if ((it.op == OP_LOAD_VERTEX ? vcount : ncount) >= STORE_N) begin
					r.kind = KIND_OVERFLOW;
				end else if (it.op == OP_LOAD_VERTEX) begin
					r.kind = KIND_VERTEX;
					r.idx = vcount[11:0];
					r.vec = it.vec;
					vstore[vcount++] = it.vec;
				end else begin
					r.kind = KIND_NORMAL;
					r.idx = ncount[11:0];
					r.vec = it.vec;
					nstore[ncount++] = it.vec;
				end
				r.last = 1;
				add_exp(r);
				return;
			end
			for (int i = 0; i < 3; i++) begin
				mv[i] = '0; mn[i] = '0; fv[i] = 0; fn[i] = 0;
			end
			lookup(0, it.cv, mv, fv);
			for (int i = 0; i < 3; i++)
				if (it.cn[i] == it.cn[(i+1)%3]) begin
					mn[i] = it.cn[i];
					fn[i] = 1;
				end
			if (!(fn[0] && fn[1] && fn[2])) lookup(1, it.cn, mn, fn);
			needv = 0;
			needn = 0;
			for (int i = 0; i < 3; i++) begin
				needv += !fv[i];
				needn += !fn[i];
			end
			if (vcount + needv > STORE_N || ecount + needv > STORE_N ||
					ncount + needn > STORE_N || pcount + needn > STORE_N) begin
				r.kind = KIND_OVERFLOW;
				r.last = 1;
				add_exp(r);
				return;
			end
			for (int i = 0; i < 3; i++) if (!fv[i]) begin
				r = '0;
				r.kind = KIND_VERTEX;
				r.vec = lane_avg(vstore[it.cv[i]], vstore[it.cv[(i+1)%3]]);
				mv[i] = vcount[11:0];
				r.idx = mv[i];
				vstore[vcount++] = r.vec;
				edge_lo[ecount] = it.cv[i];
				edge_hi[ecount] = it.cv[(i+1)%3];
				edge_mid[ecount++] = mv[i];
				add_exp(r);
			end
			for (int i = 0; i < 3; i++) if (!fn[i]) begin
				r = '0;
				r.kind = KIND_NORMAL;
				r.vec = lane_avg(nstore[it.cn[i]], nstore[it.cn[(i+1)%3]]);
				mn[i] = ncount[11:0];
				r.idx = mn[i];
				nstore[ncount++] = r.vec;
				pair_lo[pcount] = it.cn[i];
				pair_hi[pcount] = it.cn[(i+1)%3];
				pair_mid[pcount++] = mn[i];
				add_exp(r);
			end
			for (int i = 0; i < 3; i++) mu[i] = uv_avg(it.uv[i], it.uv[(i+1)%3]);
			a3 = '{it.cv[0], mv[0], mv[2]}; b3 = '{it.cn[0], mn[0], mn[2]};
			u3 = '{it.uv[0], mu[0], mu[2]};
			add_exp(tri_res(a3, b3, u3));
			a3 = '{mv[0], mv[1], mv[2]}; b3 = '{mn[0], mn[1], mn[2]};
			u3 = '{mu[0], mu[1], mu[2]};
			add_exp(tri_res(a3, b3, u3));
			a3 = '{mv[0], it.cv[1], mv[1]}; b3 = '{mn[0], it.cn[1], mn[1]};
			u3 = '{mu[0], it.uv[1], mu[1]};
			add_exp(tri_res(a3, b3, u3));
			a3 = '{mv[2], mv[1], it.cv[2]}; b3 = '{mn[2], mn[1], it.cn[2]};
			u3 = '{mu[2], mu[1], it.uv[2]};
			add_exp(tri_res(a3, b3, u3));
			pending[pending.size()-1].last = 1;
		endfunction

		function void check_result(res_t got);
			res_t exp_r;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected transfer: %h", got);
				return;
			end
			exp_r = pending.pop_front();
			if (got.kind !== exp_r.kind || got.idx !== exp_r.idx || got.vec !== exp_r.vec ||
					got.va !== exp_r.va || got.vb !== exp_r.vb || got.vc !== exp_r.vc ||
					got.na !== exp_r.na || got.nb !== exp_r.nb || got.nc !== exp_r.nc ||
					got.uvab !== exp_r.uvab || got.uvc !== exp_r.uvc ||
					got.last !== exp_r.last) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch kind/idx/vec exp %0d %h %h got %0d %h %h",
						exp_r.kind, exp_r.idx, exp_r.vec, got.kind, got.idx, got.vec);
					$display("  tri exp %h %h %h %h %h %h %h %h last %b",
						exp_r.va, exp_r.vb, exp_r.vc, exp_r.na, exp_r.nb, exp_r.nc,
						exp_r.uvab, exp_r.uvc, exp_r.last);
					$display("  tri got %h %h %h %h %h %h %h %h last %b",
						got.va, got.vb, got.vc, got.na, got.nb, got.nc,
						got.uvab, got.uvc, got.last);
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [S_DATA_W-1:0] s_tdata;
	logic [1:0] s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [M_DATA_W-1:0] m_tdata;
	logic [1:0] m_tuser;
	logic m_tlast;

	subdiv_scoreboard sb;
	bit idle_en;
	int cycles;
	logic [11:0] prev_cv[3];

	triangle_midpoint_subdivider dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		res_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.kind = m_tuser;
			got.idx = m_tdata[11:0];
			got.vec = m_tdata[59:12];
			{got.vc, got.vb, got.va} = m_tdata[95:60];
			{got.nc, got.nb, got.na} = m_tdata[131:96];
			got.uvab = m_tdata[195:132];
			got.uvc = m_tdata[227:196];
			got.last = m_tlast;
			sb.check_result(got);
		end
	end

	// output backpressure in bursts
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (idle_en && $urandom_range(0, 9) == 0) begin
				m_tready = 1'b0;
				repeat ($urandom_range(1, 17)) @(negedge clk);
			end
			m_tready = 1'b1;
		end
	end

	task automatic send(req_t it);
		@(negedge clk);
		s_tuser = it.op;
		s_tdata = '0;
		s_tdata[215:0] = {it.uv[2], it.uv[1], it.uv[0], it.cn[2], it.cn[1], it.cn[0],
			it.cv[2], it.cv[1], it.cv[0], it.vec};
		s_tvalid = 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_transfer(it);
		@(negedge clk);
		s_tvalid = 1'b0;
		if (idle_en && $urandom_range(0, 5) == 0) begin
			repeat ($urandom_range(0, 16)) @(negedge clk);
		end
	endtask

	function automatic req_t blank(logic [1:0] op);
		req_t it;
		it.op = op;
		it.vec = 48'({$urandom, $urandom});
		for (int i = 0; i < 3; i++) begin
			it.cv[i] = '0;
			it.cn[i] = '0;
			it.uv[i] = $urandom;
		end
		return it;
	endfunction

	task automatic load(logic [1:0] op, logic [47:0] v);
		req_t it;
		it = blank(op);
		it.vec = v;
		send(it);
	endtask

	task automatic tri3(logic [11:0] a, logic [11:0] b, logic [11:0] c,
			logic [11:0] na, logic [11:0] nb, logic [11:0] nc);
		req_t it;
		it = blank(OP_SUBDIVIDE);
		it.cv = '{a, b, c};
		it.cn = '{na, nb, nc};
		send(it);
	endtask

	task automatic random_tri(int vmax, int nmax);
		req_t it;
		it = blank(OP_SUBDIVIDE);
		case ($urandom_range(0, 3))
			0: it.cv = '{12'($urandom_range(0, vmax)), 12'($urandom_range(0, vmax)),
				12'($urandom_range(0, vmax))};
			1: it.cv = '{prev_cv[1], prev_cv[0], 12'($urandom_range(0, vmax))};
			2: it.cv = '{prev_cv[2], 12'($urandom_range(0, vmax)), prev_cv[1]};
			default: it.cv = prev_cv;
		endcase
		for (int i = 0; i < 3; i++) it.cn[i] = 12'($urandom_range(0, nmax));
		if ($urandom_range(0, 3) == 0) it.cn[1] = it.cn[0];
		prev_cv = it.cv;
		send(it);
	endtask

	task automatic drain();
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		req_t it;
		int r;
		sb = new();
		idle_en = 1'b1;
		cycles = 0;
		prev_cv = '{12'd0, 12'd1, 12'd2};
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = OP_LOAD_VERTEX;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: lane extremes, shared and reversed edges, equal normals, uv extremes
		load(OP_LOAD_VERTEX, 48'h7fff_7fff_7fff);
		load(OP_LOAD_VERTEX, 48'h8000_8000_8000);
		load(OP_LOAD_VERTEX, 48'hffff_0000_ffff);
		load(OP_LOAD_VERTEX, 48'h0000_ffff_0001);
		load(OP_LOAD_NORMAL, 48'h7fff_8000_0000);
		load(OP_LOAD_NORMAL, 48'hffff_ffff_ffff);
		load(OP_LOAD_NORMAL, 48'h8000_7fff_0001);
		it = blank(OP_SUBDIVIDE);
		it.cv = '{12'd0, 12'd1, 12'd2};
		it.cn = '{12'd0, 12'd1, 12'd2};
		it.uv = '{32'hffff_ffff, 32'h0000_0000, 32'hffff_0001};
		send(it);
		send(it);
		tri3(12'd1, 12'd0, 12'd3, 12'd1, 12'd0, 12'd0);
		tri3(12'd2, 12'd3, 12'd1, 12'd2, 12'd2, 12'd2);
		tri3(12'd3, 12'd3, 12'd0, 12'd1, 12'd2, 12'd1);
		send(blank(OP_CLEAR));
		tri3(12'd0, 12'd1, 12'd2, 12'd0, 12'd1, 12'd2);
		tri3(12'd2, 12'd1, 12'd0, 12'd2, 12'd1, 12'd0);

		for (int k = 0; k < 170; k++) begin
			if (k == 100) drain();
			r = $urandom_range(0, 19);
			if (sb.ecount > 80 || r == 5) send(blank(OP_CLEAR));
			else if (r < 3) send(blank(OP_LOAD_VERTEX));
			else if (r < 5) send(blank(OP_LOAD_NORMAL));
			else random_tri(sb.vcount - 1, sb.ncount - 1);
		end

		// no idling from here
		idle_en = 1'b0;
		drain();
		send(blank(OP_CLEAR));
		for (int k = 0; k < 15; k++) begin
			r = $urandom_range(0, 19);
			if (r < 3) send(blank(OP_LOAD_VERTEX));
			else if (r < 5) send(blank(OP_LOAD_NORMAL));
			else random_tri(sb.vcount - 1, sb.ncount - 1);
		end

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/tms_pkg.sv
rtl/tms_ram.sv
rtl/tms_match.sv
rtl/triangle_midpoint_subdivider.sv
bench/tb_top.sv
